// ----- src/triangle_unit_normal_macros.svh -----
// Assertion macros for the RTL.
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define TUN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define TUN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define TUN_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define TUN_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/tun_pkg.sv -----
package tun_pkg;

   localparam int COORD_BITS       = 16;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int FIELD_W          = 16;

   // Edge vectors, products, cross product and its square.
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W;
   localparam int MAG_W   = CROSS_W - 1;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = SQ_W + 2;

   // Square-comparison search: remainder, q*s and increments fit here.
   localparam int R_SHIFT = 2 * NORMAL_FRAC_BITS + 2;
   localparam int WORK_W  = SUM_W + 2 * NORMAL_FRAC_BITS + 4;
   localparam int NORM_W  = NORMAL_FRAC_BITS + 1;
   localparam int ITER    = NORMAL_FRAC_BITS;

   // Register stages from input acceptance to the output register.
   localparam int LATENCY = ITER + 8;

   typedef struct packed {
      logic signed [FIELD_W-1:0] x;
      logic signed [FIELD_W-1:0] y;
      logic signed [FIELD_W-1:0] z;
   } vertex_type;

   typedef struct packed {
      logic sign;
      logic zero;
   } tun_ctl_type;

   // Low COORD_BITS of a field, sign-extended to the difference width.
   function automatic logic signed [DIFF_W-1:0] coord_ext(input logic [FIELD_W-1:0] raw);
      return DIFF_W'(signed'(raw[COORD_BITS-1:0]));
   endfunction

endpackage

// ----- src/tun_channels.sv -----
interface tun_req_if;
   import tun_pkg::*;
   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  first_x;
   logic [FIELD_W-1:0]  first_y;
   logic [FIELD_W-1:0]  first_z;
   logic [FIELD_W-1:0]  second_x;
   logic [FIELD_W-1:0]  second_y;
   logic [FIELD_W-1:0]  second_z;
   logic [FIELD_W-1:0]  third_x;
   logic [FIELD_W-1:0]  third_y;
   logic [FIELD_W-1:0]  third_z;

   modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   third_x, third_y, third_z, input ready);
   modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 third_x, third_y, third_z, output ready);
endinterface

interface tun_rsp_if;
   import tun_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [FIELD_W-1:0]  normal_x;
   logic signed [FIELD_W-1:0]  normal_y;
   logic signed [FIELD_W-1:0]  normal_z;
   logic                       degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ----- src/tun_cross.sv -----
// Edge vectors, cross product and squared components: five register stages.
module tun_cross (
   input  logic                                clock,
   input  logic                                enable,
   input  tun_pkg::vertex_type                 first,
   input  tun_pkg::vertex_type                 second,
   input  tun_pkg::vertex_type                 third,
   output logic [2:0][tun_pkg::SQ_W-1:0]       sq,
   output logic [2:0]                          sign
);
   import tun_pkg::*;

   logic signed [DIFF_W-1:0]  u_ff [3];
   logic signed [DIFF_W-1:0]  v_ff [3];
   logic signed [DIFF_W-1:0]  u_in [3];
   logic signed [DIFF_W-1:0]  v_in [3];
   logic signed [PROD_W-1:0]  prod_ff [6];
   logic signed [PROD_W-1:0]  prod_in [6];
   logic signed [CROSS_W-1:0] cross_ff [3];
   logic signed [CROSS_W-1:0] cross_in [3];
   logic [MAG_W-1:0]          mag_ff [3];
   logic [MAG_W-1:0]          mag_in [3];
   logic [2:0]                sign_a_ff;
   logic [2:0]                sign_a_in;
   logic [2:0]                sign_b_ff;
   logic [SQ_W-1:0]           sq_ff [3];
   logic [SQ_W-1:0]           sq_in [3];
   logic signed [CROSS_W-1:0] neg [3];

   // Stage 1: edge vectors U = P2 - P1, V = P3 - P1
   always_comb begin
      u_in[0] = coord_ext(second.x) - coord_ext(first.x);
      u_in[1] = coord_ext(second.y) - coord_ext(first.y);
      u_in[2] = coord_ext(second.z) - coord_ext(first.z);
      v_in[0] = coord_ext(third.x) - coord_ext(first.x);
      v_in[1] = coord_ext(third.y) - coord_ext(first.y);
      v_in[2] = coord_ext(third.z) - coord_ext(first.z);
   end

   // Stage 2: six partial products
   always_comb begin
      prod_in[0] = u_ff[1] * v_ff[2];
      prod_in[1] = u_ff[2] * v_ff[1];
      prod_in[2] = u_ff[2] * v_ff[0];
      prod_in[3] = u_ff[0] * v_ff[2];
      prod_in[4] = u_ff[0] * v_ff[1];
      prod_in[5] = u_ff[1] * v_ff[0];
   end

   // Stages 3 to 5: difference, magnitude and sign, square
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cross_in[k]  = prod_ff[2*k] - prod_ff[2*k+1];
         neg[k]       = -cross_ff[k];
         sign_a_in[k] = cross_ff[k][CROSS_W-1];
         mag_in[k]    = sign_a_in[k] ? neg[k][MAG_W-1:0] : cross_ff[k][MAG_W-1:0];
         sq_in[k]     = SQ_W'(mag_ff[k]) * SQ_W'(mag_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         u_ff      <= u_in;
         v_ff      <= v_in;
         prod_ff   <= prod_in;
         cross_ff  <= cross_in;
         mag_ff    <= mag_in;
         sign_a_ff <= sign_a_in;
         sq_ff     <= sq_in;
         sign_b_ff <= sign_a_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq[k] = sq_ff[k];
      end
      sign = sign_b_ff;
   end

endmodule

// ----- src/tun_norm_lane.sv -----
// One component: rounded |c| * 2^F / sqrt(s) by a pipelined search that
// builds q = 2m - 1 one bit per stage, tracking R - q^2*s and q*s with
// shifts and adds only. One init stage, ITER search stages, one output stage.
module tun_norm_lane (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [tun_pkg::WORK_W-1:0]         r,
   input  logic [tun_pkg::SUM_W-1:0]          s,
   input  logic                               sign,
   output logic signed [tun_pkg::FIELD_W-1:0] normal,
   output logic                               zero
);
   import tun_pkg::*;

   logic [WORK_W-1:0]           rem_ff [ITER+1];
   logic [WORK_W-1:0]           t_ff   [ITER+1];
   logic [SUM_W-1:0]            s_ff   [ITER+1];
   logic [NORMAL_FRAC_BITS-1:0] j_ff   [ITER+1];
   logic                        ok_ff  [ITER+1];
   tun_ctl_type                 ctl_ff [ITER+1];
   logic [WORK_W-1:0]           s_wide;
   logic                        ok_in;
   logic [NORM_W-1:0]           m;
   logic signed [FIELD_W-1:0]   out_in;
   logic signed [FIELD_W-1:0]   out_ff;
   logic                        zero_ff;

   // Init: q = 1 fits when s <= R, otherwise the magnitude is zero
   assign s_wide = WORK_W'(s);
   assign ok_in  = r >= s_wide;

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]      <= r - s_wide;
         t_ff[0]        <= s_wide;
         s_ff[0]        <= s;
         j_ff[0]        <= '0;
         ok_ff[0]       <= ok_in;
         ctl_ff[0].sign <= sign;
         ctl_ff[0].zero <= (s == '0);
      end
   end

   // Search stages: try bit K of j, i.e. add 2^(K+1) to q
   for (genvar i = 0; i < ITER; i++) begin : g_step
      localparam int K = NORMAL_FRAC_BITS - 1 - i;
      logic [WORK_W-1:0]           sb;
      logic [WORK_W-1:0]           inc;
      logic                        take;
      logic [WORK_W-1:0]           rem_in;
      logic [WORK_W-1:0]           t_in;
      logic [NORMAL_FRAC_BITS-1:0] j_in;

      always_comb begin
         sb   = WORK_W'(s_ff[i]) << (K + 1);
         inc  = ((t_ff[i] << 1) + sb) << (K + 1);
         take = rem_ff[i] >= inc;
         rem_in = take ? rem_ff[i] - inc : rem_ff[i];
         t_in   = take ? t_ff[i] + sb : t_ff[i];
         j_in    = j_ff[i];
         j_in[K] = take;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i+1] <= rem_in;
            t_ff[i+1]   <= t_in;
            s_ff[i+1]   <= s_ff[i];
            j_ff[i+1]   <= j_in;
            ok_ff[i+1]  <= ok_ff[i];
            ctl_ff[i+1] <= ctl_ff[i];
         end
      end
   end

   // Output: m = j + 1, sign applied, zeroed for a degenerate triangle
   always_comb begin
      m = ok_ff[ITER] ? NORM_W'(j_ff[ITER]) + NORM_W'(1) : '0;
      if (ctl_ff[ITER].zero) begin
         out_in = '0;
      end else if (ctl_ff[ITER].sign) begin
         out_in = -FIELD_W'(m);
      end else begin
         out_in = FIELD_W'(m);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff  <= out_in;
         zero_ff <= ctl_ff[ITER].zero;
      end
   end

   assign normal = out_ff;
   assign zero   = zero_ff;

endmodule

// ----- src/triangle_unit_normal.sv -----
// Unit face normal of a triangle.
// req_chan carries one triangle per transaction: three vertices, each
// coordinate signed Q8.8. rsp_chan returns one transaction per triangle:
// the unit normal of (P2-P1) x (P3-P1) in signed Q1.14, rounded to nearest
// (ties away from zero), and a degenerate flag with zero components when
// the cross product is the zero vector.
// Pipeline: 22 register stages (5 cross-product stages, 1 sum stage, 1 init
// stage, 14 search stages one per result bit, 1 output stage).
// Throughput: one transaction per cycle while the output is not stalled; the
// search is fully unrolled into stages, one bit of each component resolved per stage.
// All stages advance together; when the receiver holds rsp_chan.ready low
// with a result waiting, the pipeline freezes and req_chan.ready drops,
// nothing is lost or repeated. Pipeline bubbles advance while no result waits.
// Synchronous reset clears the stage valid bits; no result is pending.
`include "triangle_unit_normal_macros.svh"

module triangle_unit_normal (
   input  logic      clock,
   input  logic      reset,
   tun_req_if.sink   req_chan,
   tun_rsp_if.source rsp_chan
);
   import tun_pkg::*;

   logic                  advance;
   logic [LATENCY-1:0]    valid_ff;
   logic [LATENCY-1:0]    valid_in;
   vertex_type            first;
   vertex_type            second;
   vertex_type            third;
   logic [2:0][SQ_W-1:0]  sq;
   logic [2:0]            sign;
   logic [SUM_W-1:0]      s_ff;
   logic [WORK_W-1:0]     r_ff [3];
   logic [2:0]            sign_ff;
   logic signed [FIELD_W-1:0] normal [3];
   logic [2:0]            zero;

   // Whole pipeline moves when the output register is free or being taken
   assign advance        = !valid_ff[LATENCY-1] || rsp_chan.ready;
   assign req_chan.ready = advance;

   assign first  = '{x: req_chan.first_x,  y: req_chan.first_y,  z: req_chan.first_z};
   assign second = '{x: req_chan.second_x, y: req_chan.second_y, z: req_chan.second_z};
   assign third  = '{x: req_chan.third_x,  y: req_chan.third_y,  z: req_chan.third_z};

   // Valid bits travel with the data
   assign valid_in = {valid_ff[LATENCY-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   tun_cross u_cross (
      .clock  (clock),
      .enable (advance),
      .first  (first),
      .second (second),
      .third  (third),
      .sq     (sq),
      .sign   (sign)
   );

   // Squared length and scaled squares
   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
         for (int k = 0; k < 3; k++) begin
            r_ff[k] <= WORK_W'(sq[k]) << R_SHIFT;
         end
         sign_ff <= sign;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      tun_norm_lane u_lane (
         .clock  (clock),
         .enable (advance),
         .r      (r_ff[k]),
         .s      (s_ff),
         .sign   (sign_ff[k]),
         .normal (normal[k]),
         .zero   (zero[k])
      );
   end

   assign rsp_chan.valid      = valid_ff[LATENCY-1];
   assign rsp_chan.normal_x   = normal[0];
   assign rsp_chan.normal_y   = normal[1];
   assign rsp_chan.normal_z   = normal[2];
   assign rsp_chan.degenerate = zero[0];

   // Degenerate results carry zero components
   `TUN_ASSERT_NOW(a_degen_zero, clock, reset, rsp_chan.valid && zero[0],
      normal[0] == '0 && normal[1] == '0 && normal[2] == '0)
   // All lanes agree on the degenerate flag
   `TUN_ASSERT_NOW(a_lane_zero, clock, reset, rsp_chan.valid, zero[1] == zero[0] && zero[2] == zero[0])
   // The x component never leaves plus or minus one
   `TUN_ASSERT_NOW(a_range, clock, reset, rsp_chan.valid,
      normal[0] <= $signed(FIELD_W'(1 << NORMAL_FRAC_BITS)) &&
      normal[0] >= -$signed(FIELD_W'(1 << NORMAL_FRAC_BITS)))
   // A frozen pipeline keeps its valid bits
   `TUN_ASSERT_NEXT(a_freeze, clock, reset, !advance, $stable(valid_ff))
   // An accepted transaction enters the first stage
   `TUN_ASSERT_NEXT(a_enter, clock, reset, req_chan.valid && advance, valid_ff[0])

endmodule

// ----- verif/tb_channels.sv -----
`timescale 1ns / 1ps
// The channel interfaces live with the RTL (tun_channels.sv); this file only
// holds the item types the testbench queues.
package tb_tun_types;
   typedef struct {
      logic [15:0] fx, fy, fz, sx, sy, sz, tx, ty, tz;
   } triangle_type;

   typedef struct {
      logic [15:0] nx, ny, nz;
      logic        degen;
   } normal_type;
endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import tun_pkg::*;
   import tb_tun_types::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tun_req_if req_chan ();
   tun_rsp_if rsp_chan ();

   triangle_unit_normal u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   triangle_type pending_tris[$];
   normal_type   expected_normals[$];
   int        error_count = 0;
   int        cycle_count = 0;
   bit        stim_done = 1'b0;
   bit        calm_phase = 1'b0;
   bit        req_fire = 1'b0;
   int        hold_cycles = 0;
   int        send_gap = 0;
   int        recv_gap = 0;

   localparam int CYCLE_LIMIT = 400000;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] exp);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycle_count);
      error_count++;
   endtask

   function automatic logic signed [63:0] sext16(input logic [15:0] raw);
      return 64'(signed'(raw));
   endfunction

   // Rounded magnitude of c * 2^14 / sqrt(s), by comparing squares.
   function automatic logic [14:0] unit_mag(input logic signed [63:0] c,
                                            input logic [127:0] s);
      logic [127:0] rhs, lhs, cm;
      logic [14:0]  lo, hi, mid;
      logic [63:0]  odd;
      cm  = c < 0 ? 128'(-c) : 128'(c);
      rhs = (cm * cm) << (2 * NORMAL_FRAC_BITS + 2);
      lo  = 0;
      hi  = 15'(1 << NORMAL_FRAC_BITS);
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 64'(2 * mid - 1);
         lhs = 128'(odd * odd) * s;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic normal_type face_normal(input triangle_type t);
      normal_type r;
      logic signed [63:0] ux, uy, uz, vx, vy, vz;
      logic signed [63:0] c[3];
      logic [127:0] s;
      logic [14:0] m;
      ux = sext16(t.sx) - sext16(t.fx);
      uy = sext16(t.sy) - sext16(t.fy);
      uz = sext16(t.sz) - sext16(t.fz);
      vx = sext16(t.tx) - sext16(t.fx);
      vy = sext16(t.ty) - sext16(t.fy);
      vz = sext16(t.tz) - sext16(t.fz);
      c[0] = uy * vz - uz * vy;
      c[1] = uz * vx - ux * vz;
      c[2] = ux * vy - uy * vx;
      r = '{16'h0, 16'h0, 16'h0, 1'b1};
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) return r;
      s = 0;
      // Squares need more than 64 bits
      for (int k = 0; k < 3; k++) s += 128'(c[k]) * 128'(c[k]);
      r.degen = 1'b0;
      m = unit_mag(c[0], s); r.nx = c[0] < 0 ? -16'(m) : 16'(m);
      m = unit_mag(c[1], s); r.ny = c[1] < 0 ? -16'(m) : 16'(m);
      m = unit_mag(c[2], s); r.nz = c[2] < 0 ? -16'(m) : 16'(m);
      return r;
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic triangle_type rand_tri();
      triangle_type t;
      logic [15:0] k;
      t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      // Occasionally make it collinear or collapsed.
      case ($urandom_range(0, 9))
         0: begin t.sx = t.fx; t.sy = t.fy; t.sz = t.fz; end
         1: begin
            k = 16'($urandom_range(1, 3));
            t.sx = t.fx + k; t.sy = t.fy + 16'(2 * k); t.sz = t.fz - k;
            t.tx = t.fx + 16'(3 * k); t.ty = t.fy + 16'(6 * k); t.tz = t.fz - 16'(3 * k);
         end
         default: ;
      endcase
      return t;
   endfunction

   // Stimulus: directed extremes, then random.
   initial begin
      triangle_type t;
      pending_tris.push_back('{0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0});
      pending_tris.push_back('{0, 0, 0, 0, 16'h0100, 0, 16'h0100, 0, 0});
      pending_tris.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      pending_tris.push_back('{5, 5, 5, 6, 7, 8, 7, 9, 11});
      pending_tris.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                               16'h8000, 16'h7FFF, 16'h8000});
      pending_tris.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                               16'h7FFF, 16'h8000, 16'h7FFF});
      pending_tris.push_back('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                               16'h8000, 16'h8000, 16'h7FFF});
      pending_tris.push_back('{0, 0, 0, 1, 1, 0, 1, 0, 0});
      pending_tris.push_back('{0, 0, 0, 1, 2, 3, 2, 4, 6});
      pending_tris.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      pending_tris.push_back('{0, 0, 0, 3, 0, 0, 0, 4, 1});
      pending_tris.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 1});
      for (int i = 0; i < 1200; i++) begin
         t = rand_tri();
         pending_tris.push_back(t);
      end
   end

   // Long receiver hold-off partway through the run.
   initial begin
      hold_cycles = 0;
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_cycles = 200;
      while (hold_cycles > 0) begin
         @(posedge clock);
         hold_cycles = hold_cycles - 1;
      end
   end

   // Driver: new transaction offered on the falling edge; the monitor
   // retires the head of the queue when it is accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         calm_phase <= pending_tris.size() < 150;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_tris.size() > 0 &&
                      !(!calm_phase && !(req_chan.valid && !req_fire) &&
                        $urandom_range(0, 15) == 0)) begin
            req_chan.valid    <= 1'b1;
            req_chan.first_x  <= pending_tris[0].fx;
            req_chan.first_y  <= pending_tris[0].fy;
            req_chan.first_z  <= pending_tris[0].fz;
            req_chan.second_x <= pending_tris[0].sx;
            req_chan.second_y <= pending_tris[0].sy;
            req_chan.second_z <= pending_tris[0].sz;
            req_chan.third_x  <= pending_tris[0].tx;
            req_chan.third_y  <= pending_tris[0].ty;
            req_chan.third_z  <= pending_tris[0].tz;
         end else begin
            req_chan.valid <= 1'b0;
            if (pending_tris.size() > 0) send_gap <= $urandom_range(0, 9);
         end
         if (pending_tris.size() == 0) stim_done <= 1'b1;
         // Receiver stalls, in bursts.
         if (hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
            recv_gap <= $urandom_range(0, 9);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.first_x  = '0; req_chan.first_y  = '0; req_chan.first_z  = '0;
      req_chan.second_x = '0; req_chan.second_y = '0; req_chan.second_z = '0;
      req_chan.third_x  = '0; req_chan.third_y  = '0; req_chan.third_z  = '0;
      rsp_chan.ready    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset = 1'b0;
   end

   // Monitor: predict on accepted input, check accepted output.
   always @(posedge clock) begin
      normal_type exp_n;
      triangle_type t;
      cycle_count <= cycle_count + 1;
      req_fire = !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            t = '{req_chan.first_x, req_chan.first_y, req_chan.first_z,
                  req_chan.second_x, req_chan.second_y, req_chan.second_z,
                  req_chan.third_x, req_chan.third_y, req_chan.third_z};
            expected_normals.push_back(face_normal(t));
            void'(pending_tris.pop_front());
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_normals.size() == 0) begin
               $display("unexpected result at cycle %0d", cycle_count);
               error_count++;
            end else begin
               exp_n = expected_normals.pop_front();
               if (rsp_chan.normal_x !== exp_n.nx)
                  report_mismatch("normal_x", rsp_chan.normal_x, exp_n.nx);
               if (rsp_chan.normal_y !== exp_n.ny)
                  report_mismatch("normal_y", rsp_chan.normal_y, exp_n.ny);
               if (rsp_chan.normal_z !== exp_n.nz)
                  report_mismatch("normal_z", rsp_chan.normal_z, exp_n.nz);
               if (rsp_chan.degenerate !== exp_n.degen)
                  report_mismatch("degenerate", 16'(rsp_chan.degenerate), 16'(exp_n.degen));
            end
         end
      end
   end

   // End of run and timeout.
   initial begin
      wait (stim_done && expected_normals.size() == 0 && !reset);
      repeat (LATENCY * 4) @(posedge clock);
      if (error_count == 0 && expected_normals.size() == 0)
         $display("** triangle_unit_normal: PASSED **");
      else
         $display("** triangle_unit_normal: FAILED **");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout at cycle %0d", cycle_count);
      $display("** triangle_unit_normal: FAILED **");
      $finish;
   end
endmodule
